>>> design/qdd_pkg.sv
package qdd_pkg;

  localparam int unsigned RATE_W  = 10;
  localparam int unsigned STEPS_W = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned NOW_W   = 32;

  localparam logic [RATE_W-1:0]  RATE_LIMIT_RST = 10'd35;
  localparam logic [STEPS_W-1:0] STEPS_RST      = 4'd4;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_RATE_LIMIT = 1'b0;
  localparam logic [IDX_W-1:0] REG_STEPS      = 1'b1;

  // Two-bit signed direction codes.
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_e;

  typedef struct packed {
    logic       fire;
    logic [1:0] ab;
  } step_req_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_limit;
    logic [STEPS_W-1:0] steps;
  } cfg_t;

  // Transition code is {previous A, previous B, A, B}.
  function automatic step_e step_of(input logic [3:0] trans);
    step_e s;
    unique case (trans) inside
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_DOWN;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: s = STEP_UP;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> design/quadrature_detent_decoder.sv
// Channel    Dir  Handshake               Payload
// s_axis     in   tvalid/tready           tdata: enc_a, enc_b, now_ms
// m_axis     out  tvalid/tready           tdata: direction
// cfg        in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One sample per cycle is accepted while results are taken; each sample is
// registered in the input register and its result in the output register
// that drives m_axis. Throughput is set by the state update in qdd_step.
// When m_axis stalls, one sample waits in the input register; s_axis_tready
// drops only when both registers are full and the result is not taken.
// Reset clears the decoder state and restores the default settings.
module quadrature_detent_decoder #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] enc_a, [1] enc_b, [33:2] now_ms, [39:34] zero
  input  logic [39:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] direction, [7:2] zero
  output logic [7:0]                 m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [qdd_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [qdd_pkg::CFG_W-1:0]  cfg_data_i
);
  import qdd_pkg::*;

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  logic [1:0]           in_ab_q;
  logic [NOW_W-1:0]     in_now_q;
  logic                 out_valid_q;
  logic [1:0]           out_dir_q;
  logic                 advance;
  logic                 s_fire;
  step_req_t            req;
  logic [1:0]           dir;
  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign req.fire = in_valid_q && advance;
  assign req.ab   = {in_ab_q[0], in_ab_q[1]};
  assign now_ext  = {{(64-NOW_W){1'b0}}, in_now_q};
  assign now      = now_ext[TIME_BITS-1:0];

  qdd_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .req_i (req),
    .now_i (now),
    .dir_o (dir)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_limit <= RATE_LIMIT_RST;
      cfg_q.steps      <= STEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATE_LIMIT: cfg_q.rate_limit <= cfg_data_i[RATE_W-1:0];
        REG_STEPS:      cfg_q.steps      <= cfg_data_i[STEPS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // in_ab_q holds {enc_b, enc_a} as packed in tdata.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_ab_q  <= s_axis_tdata[1:0];
      in_now_q <= s_axis_tdata[33:2];
    end
    if (req.fire) begin
      out_dir_q <= dir;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_dir_q};

endmodule

>>> design/qdd_step.sv
module qdd_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qdd_pkg::cfg_t       cfg_i,
  input  qdd_pkg::step_req_t  req_i,
  input  logic [TIME_BITS-1:0] now_i,
  output logic [1:0]          dir_o
);
  import qdd_pkg::*;

  logic                       primed_q, primed_d;
  logic [1:0]                 prev_q, prev_d;
  logic signed [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_BITS-1:0]       last_q, last_d;

  step_e                      st;
  logic signed [COUNT_W:0]    sum;
  logic [COUNT_W:0]           mag;
  logic [STEPS_W-1:0]         thr;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       blocked;

  assign st      = step_of({prev_q, req_i.ab});
  assign sum     = {cnt_q[COUNT_W-1], cnt_q} +
                   ((st == STEP_UP) ? (COUNT_W+1)'(1) : {(COUNT_W+1){1'b1}});
  assign mag     = sum[COUNT_W] ? (COUNT_W+1)'(-sum) : (COUNT_W+1)'(sum);
  // With a setting of zero every valid step reaches a detent.
  assign thr     = cfg_i.steps;
  assign elapsed = now_i - last_q;
  assign blocked = (last_q != '0) &&
                   (elapsed < {{(TIME_BITS-RATE_W){1'b0}}, cfg_i.rate_limit});

  always_comb begin
    primed_d = primed_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    dir_o    = DIR_NONE;
    if (req_i.fire) begin
      if (!primed_q) begin
        primed_d = 1'b1;
        prev_d   = req_i.ab;
      end else if (req_i.ab != prev_q) begin
        prev_d = req_i.ab;
        if (st == STEP_NONE) begin
          cnt_d = '0;
        end else if (mag >= {{(COUNT_W+1-STEPS_W){1'b0}}, thr}) begin
          cnt_d  = '0;
          last_d = now_i;
          if (!blocked) begin
            // Only a strictly positive count reports the positive direction.
            dir_o = (sum[COUNT_W] || (sum == '0)) ? DIR_NEG : DIR_POS;
          end
        end else begin
          cnt_d = sum[COUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      prev_q   <= '0;
      cnt_q    <= '0;
      last_q   <= '0;
    end else begin
      primed_q <= primed_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
    end
  end

endmodule

>>> design/qdd_checker.sv
module qdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Direction is -1, 0 or +1 only.
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10)
    else $error("direction code out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b0)
    else $error("result padding not zero");

  // With the result register empty the input side can never be blocked.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
